// File: sv/ppa_pkg.sv
package ppa_pkg;

    localparam int PIXEL_WIDTH_DEF   = 32;
    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [2:0] MODE_UNARY    = 3'd0;
    localparam logic [2:0] MODE_ADD      = 3'd1;
    localparam logic [2:0] MODE_SUBTRACT = 3'd2;
    localparam logic [2:0] MODE_MULTIPLY = 3'd3;
    localparam logic [2:0] MODE_DIVIDE   = 3'd4;

    localparam logic [2:0] TAG_VALID = 3'd0;
    localparam logic [2:0] TAG_NULL  = 3'd1;
    localparam logic [2:0] TAG_TOP   = 3'd5;

    localparam logic [2:0] REG_OP_MODE = 3'd0;
    localparam logic [2:0] REG_COEF_A  = 3'd1;
    localparam logic [2:0] REG_COEF_B  = 3'd2;
    localparam logic [2:0] REG_COEF_C  = 3'd3;
    localparam logic [2:0] REG_COEF_D  = 3'd4;
    localparam logic [2:0] REG_COEF_E  = 3'd5;

    typedef logic [2:0] tag_t;
    typedef logic [2:0] mode_t;

    // control fields that ride alongside the divider
    typedef struct packed {
        tag_t  tag;
        mode_t mode;
        logic  dneg;
        logic  dzero;
    } ctl_t;

endpackage

// File: sv/ppa_divider.sv
module ppa_divider #(
    parameter int PIXEL_WIDTH   = ppa_pkg::PIXEL_WIDTH_DEF,
    parameter int FRACTION_BITS = ppa_pkg::FRACTION_BITS_DEF,
    parameter int PAYLOAD_W     = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  adv,
    input  logic                                  in_valid,
    input  logic [PIXEL_WIDTH+FRACTION_BITS-1:0]  num,
    input  logic [PIXEL_WIDTH-1:0]                den,
    input  logic [PAYLOAD_W-1:0]                  payload,
    output logic                                  out_valid,
    output logic [PIXEL_WIDTH+FRACTION_BITS-1:0]  quot,
    output logic [PAYLOAD_W-1:0]                  out_payload
);

    localparam int PW = PIXEL_WIDTH;
    localparam int QW = PIXEL_WIDTH + FRACTION_BITS;

    logic [QW-1:0]        v_reg;
    logic [PW-1:0]        rem_reg [QW];
    logic [QW-1:0]        n_reg   [QW];
    logic [PW-1:0]        d_reg   [QW];
    logic [PAYLOAD_W-1:0] p_reg   [QW];

    // one quotient bit per stage; the numerator register fills with quotient bits
    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic                 src_v;
        logic [PW-1:0]        src_rem;
        logic [QW-1:0]        src_n;
        logic [PW-1:0]        src_d;
        logic [PAYLOAD_W-1:0] src_p;
        logic [PW:0]          trial;
        logic                 ge;
        logic [PW:0]          diff;
        logic [PW-1:0]        rem_next;
        logic [QW-1:0]        n_next;

        if (k == 0) begin : g_first
            assign src_v   = in_valid;
            assign src_rem = '0;
            assign src_n   = num;
            assign src_d   = den;
            assign src_p   = payload;
        end
        else begin : g_rest
            assign src_v   = v_reg[k-1];
            assign src_rem = rem_reg[k-1];
            assign src_n   = n_reg[k-1];
            assign src_d   = d_reg[k-1];
            assign src_p   = p_reg[k-1];
        end

        always_comb
        begin
            trial    = {src_rem, src_n[QW-1]};
            ge       = trial >= {1'b0, src_d};
            diff     = trial - {1'b0, src_d};
            rem_next = ge ? diff[PW-1:0] : trial[PW-1:0];
            n_next   = {src_n[QW-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= src_v;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= rem_next;
                n_reg[k]   <= n_next;
                d_reg[k]   <= src_d;
                p_reg[k]   <= src_p;
            end
        end
    end

    assign out_valid   = v_reg[QW-1];
    assign quot        = n_reg[QW-1];
    assign out_payload = p_reg[QW-1];

endmodule

// File: sv/pixel_pair_algebra_core.sv
// channel   direction  signals
// in        input      in_valid/in_ready, first_pixel, first_special, second_pixel,
//                      second_special
// out       output     out_valid/out_ready, result_pixel, result_special
// cfg       input      cfg_we, cfg_index, cfg_data (write only)
//
// one transaction per cycle while the output is not stalled; every transaction passes
// through the bit-per-stage restoring divider
// rst_n clears all valid bits and loads the register reset values
// when the output register holds an untaken result the whole pipeline holds
module pixel_pair_algebra_core #(
    parameter int PIXEL_WIDTH   = ppa_pkg::PIXEL_WIDTH_DEF,
    parameter int FRACTION_BITS = ppa_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [PIXEL_WIDTH-1:0] first_pixel,
    input  logic [2:0]                    first_special,
    input  logic signed [PIXEL_WIDTH-1:0] second_pixel,
    input  logic [2:0]                    second_special,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [PIXEL_WIDTH-1:0] result_pixel,
    output logic [2:0]                    result_special,
    input  logic                          cfg_we,
    input  logic [2:0]                    cfg_index,
    input  logic [PIXEL_WIDTH-1:0]        cfg_data
);

    localparam int PW = PIXEL_WIDTH;
    localparam int F  = FRACTION_BITS;
    localparam int QW = PW + F;
    localparam int MW = 2 * PW + F;
    localparam int CW = $bits(ppa_pkg::ctl_t);
    localparam int PLW = PW + CW;
    localparam logic [MW-1:0] POS_LIM = {{(MW-PW+1){1'b0}}, {(PW-1){1'b1}}};
    localparam logic [MW-1:0] NEG_LIM = POS_LIM + MW'(1);

    function automatic logic [PW-1:0] sat_mag(input logic neg, input logic [MW-1:0] mag);
        logic [PW-1:0] r;
        if (neg)
        begin
            r = (mag > NEG_LIM) ? {1'b1, {(PW-1){1'b0}}} : PW'(-mag[PW-1:0]);
        end
        else
        begin
            r = (mag > POS_LIM) ? {1'b0, {(PW-1){1'b1}}} : mag[PW-1:0];
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] sat_wide(input logic [PW:0] s);
        logic [PW-1:0] r;
        if (s[PW] != s[PW-1])
        begin
            r = s[PW] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
        end
        else
        begin
            r = s[PW-1:0];
        end
        return r;
    endfunction

    function automatic logic [PW-1:0] sat_add(input logic [PW-1:0] x, input logic [PW-1:0] y);
        return sat_wide({x[PW-1], x} + {y[PW-1], y});
    endfunction

    function automatic logic [PW-1:0] sat_sub(input logic [PW-1:0] x, input logic [PW-1:0] y);
        return sat_wide({x[PW-1], x} - {y[PW-1], y});
    endfunction

    function automatic logic [PW-1:0] mag_of(input logic [PW-1:0] x);
        return x[PW-1] ? PW'(-x) : x;
    endfunction

    // configuration registers
    logic [2:0]    op_mode_reg;
    logic [PW-1:0] coef_a_reg, coef_b_reg, coef_c_reg, coef_d_reg, coef_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_mode_reg <= ppa_pkg::MODE_UNARY;
            coef_a_reg  <= PW'(1) << F;
            coef_b_reg  <= PW'(1) << F;
            coef_c_reg  <= '0;
            coef_d_reg  <= '0;
            coef_e_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppa_pkg::REG_OP_MODE: op_mode_reg <= cfg_data[2:0];
                ppa_pkg::REG_COEF_A:  coef_a_reg  <= cfg_data;
                ppa_pkg::REG_COEF_B:  coef_b_reg  <= cfg_data;
                ppa_pkg::REG_COEF_C:  coef_c_reg  <= cfg_data;
                ppa_pkg::REG_COEF_D:  coef_d_reg  <= cfg_data;
                ppa_pkg::REG_COEF_E:  coef_e_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;

    // stage 1: offsets and early tag
    logic          v1_reg;
    logic [PW-1:0] diff1_reg, diff2_reg;
    ppa_pkg::tag_t tag1_reg;
    ppa_pkg::tag_t tag1_next;

    always_comb
    begin
        if (first_special != ppa_pkg::TAG_VALID)
        begin
            tag1_next = (first_special > ppa_pkg::TAG_TOP) ? ppa_pkg::TAG_NULL : first_special;
        end
        else if (op_mode_reg == ppa_pkg::MODE_UNARY)
        begin
            tag1_next = ppa_pkg::TAG_VALID;
        end
        else if (op_mode_reg > ppa_pkg::MODE_DIVIDE || second_special != ppa_pkg::TAG_VALID)
        begin
            tag1_next = ppa_pkg::TAG_NULL;
        end
        else
        begin
            tag1_next = ppa_pkg::TAG_VALID;
        end
    end

    // stage 2: gain products on magnitudes
    logic            v2_reg;
    logic [2*PW-1:0] prod1_reg, prod2_reg;
    logic            neg1_reg, neg2_reg;
    ppa_pkg::tag_t   tag2_reg;

    // stage 3: scaled and saturated operands
    logic          v3_reg;
    logic [PW-1:0] op1_reg, op2_reg;
    ppa_pkg::tag_t tag3_reg;

    // stage 4: add, subtract, product of operands
    logic            v4_reg;
    logic [PW-1:0]   sum_reg, dif_reg, op1b_reg, op2b_reg;
    logic [2*PW-1:0] mprod_reg;
    logic            mneg_reg;
    ppa_pkg::tag_t   tag4_reg;

    // stage 5: select non-divide value, prepare divider operands
    logic          v5_reg;
    logic [PW-1:0] val5_reg;
    logic [QW-1:0] num5_reg;
    logic [PW-1:0] den5_reg;
    ppa_pkg::ctl_t ctl5_reg;
    logic [PW-1:0] mul_res, val5_next;

    always_comb
    begin
        mul_res = sat_mag(mneg_reg, MW'(mprod_reg >> F));
        case (op_mode_reg)
            ppa_pkg::MODE_UNARY:    val5_next = op1b_reg;
            ppa_pkg::MODE_ADD:      val5_next = sum_reg;
            ppa_pkg::MODE_SUBTRACT: val5_next = dif_reg;
            ppa_pkg::MODE_MULTIPLY: val5_next = mul_res;
            default:                val5_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff1_reg <= (op_mode_reg == ppa_pkg::MODE_UNARY) ? first_pixel
                                                              : sat_sub(first_pixel, coef_d_reg);
            diff2_reg <= sat_sub(second_pixel, coef_e_reg);
            tag1_reg  <= tag1_next;

            prod1_reg <= (2*PW)'(mag_of(diff1_reg)) * (2*PW)'(mag_of(coef_a_reg));
            prod2_reg <= (2*PW)'(mag_of(diff2_reg)) * (2*PW)'(mag_of(coef_b_reg));
            neg1_reg  <= diff1_reg[PW-1] ^ coef_a_reg[PW-1];
            neg2_reg  <= diff2_reg[PW-1] ^ coef_b_reg[PW-1];
            tag2_reg  <= tag1_reg;

            op1_reg  <= sat_mag(neg1_reg, MW'(prod1_reg >> F));
            op2_reg  <= sat_mag(neg2_reg, MW'(prod2_reg >> F));
            tag3_reg <= tag2_reg;

            sum_reg   <= sat_add(op1_reg, op2_reg);
            dif_reg   <= sat_sub(op1_reg, op2_reg);
            mprod_reg <= (2*PW)'(mag_of(op1_reg)) * (2*PW)'(mag_of(op2_reg));
            mneg_reg  <= op1_reg[PW-1] ^ op2_reg[PW-1];
            op1b_reg  <= op1_reg;
            op2b_reg  <= op2_reg;
            tag4_reg  <= tag3_reg;

            val5_reg       <= val5_next;
            num5_reg       <= QW'(mag_of(op1b_reg)) << F;
            den5_reg       <= mag_of(op2b_reg);
            ctl5_reg.tag   <= tag4_reg;
            ctl5_reg.mode  <= op_mode_reg;
            ctl5_reg.dneg  <= op1b_reg[PW-1] ^ op2b_reg[PW-1];
            ctl5_reg.dzero <= (op2b_reg == '0);
        end
    end

    logic           dv;
    logic [QW-1:0]  dquot;
    logic [PLW-1:0] dpay;

    ppa_divider #(
        .PIXEL_WIDTH   (PW),
        .FRACTION_BITS (F),
        .PAYLOAD_W     (PLW)
    ) u_div (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_valid    (v5_reg),
        .num         (num5_reg),
        .den         (den5_reg),
        .payload     ({val5_reg, ctl5_reg}),
        .out_valid   (dv),
        .quot        (dquot),
        .out_payload (dpay)
    );

    // final stage: divide select, constant offset, special zeroing
    ppa_pkg::ctl_t dctl;
    logic [PW-1:0] dval, pre_val, fin_val;
    ppa_pkg::tag_t fin_tag;
    logic          out_valid_reg;
    logic [PW-1:0] result_pixel_reg;
    ppa_pkg::tag_t result_special_reg;

    always_comb
    begin
        dctl    = ppa_pkg::ctl_t'(dpay[CW-1:0]);
        dval    = dpay[PLW-1:CW];
        fin_tag = dctl.tag;
        pre_val = dval;
        if (dctl.mode == ppa_pkg::MODE_DIVIDE)
        begin
            pre_val = sat_mag(dctl.dneg, MW'(dquot));
            if (dctl.dzero && dctl.tag == ppa_pkg::TAG_VALID)
            begin
                fin_tag = ppa_pkg::TAG_NULL;
            end
        end
        fin_val = (fin_tag == ppa_pkg::TAG_VALID) ? sat_add(pre_val, coef_c_reg) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            result_pixel_reg   <= fin_val;
            result_special_reg <= fin_tag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign result_pixel   = result_pixel_reg;
    assign result_special = result_special_reg;

`ifndef ASSERT_OFF
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_special != ppa_pkg::TAG_VALID |-> result_pixel == '0)
        else $error("special result with nonzero pixel");

    a_tag_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> result_special <= ppa_pkg::TAG_TOP)
        else $error("result tag out of range");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(dv) && $stable(dquot))
        else $error("divider moved during stall");
`endif

endmodule

// File: tb/pixel_pair_algebra_core_test.sv
module pixel_pair_algebra_core_test;

    localparam int PW = ppa_pkg::PIXEL_WIDTH_DEF;
    localparam int FB = ppa_pkg::FRACTION_BITS_DEF;
    localparam longint PIX_HI = (longint'(1) <<< (PW - 1)) - 1;
    localparam longint PIX_LO = -(longint'(1) <<< (PW - 1));
    localparam int LATENCY = PW + FB + 6;
    localparam int CYCLE_LIMIT = 600000;
    // first operator code past divide, treated as unknown
    localparam ppa_pkg::mode_t MODE_UNUSED = 3'd5;

    typedef struct {
        logic signed [PW-1:0] p1;
        ppa_pkg::tag_t        t1;
        logic signed [PW-1:0] p2;
        ppa_pkg::tag_t        t2;
    } pair_t;

    typedef struct {
        logic signed [PW-1:0] pix;
        ppa_pkg::tag_t        tag;
    } pixel_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [PW-1:0] first_pixel = '0;
    ppa_pkg::tag_t first_special = ppa_pkg::TAG_VALID;
    logic signed [PW-1:0] second_pixel = '0;
    ppa_pkg::tag_t second_special = ppa_pkg::TAG_VALID;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [PW-1:0] result_pixel;
    ppa_pkg::tag_t result_special;
    logic cfg_we = 1'b0;
    logic [2:0] cfg_index = '0;
    logic [PW-1:0] cfg_data = '0;

    pair_t          pending_pairs[$];
    pixel_t         expected_pixels[$];
    ppa_pkg::mode_t cur_mode;
    longint gain_a, gain_b, bias_c, offs_d, offs_e;
    int     errors = 0;
    int     checked = 0;
    int     cycles = 0;
    int     in_gap = 0;
    int     out_gap = 0;
    bit     steady = 0;

    pixel_pair_algebra_core dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic longint clamp(longint x);
        if (x > PIX_HI) return PIX_HI;
        if (x < PIX_LO) return PIX_LO;
        return x;
    endfunction

    function automatic longint q_mul(longint x, longint y);
        return clamp((x * y) / (longint'(1) <<< FB));
    endfunction

    function automatic pixel_t compute_pixel(pair_t p);
        pixel_t r;
        longint v, op1, op2;
        r.tag = ppa_pkg::TAG_VALID;
        v = 0;
        if (p.t1 != ppa_pkg::TAG_VALID)
            r.tag = (p.t1 > ppa_pkg::TAG_TOP) ? ppa_pkg::TAG_NULL : p.t1;
        else if (cur_mode == ppa_pkg::MODE_UNARY)
            v = clamp(q_mul(p.p1, gain_a) + bias_c);
        else if (cur_mode > ppa_pkg::MODE_DIVIDE || p.t2 != ppa_pkg::TAG_VALID)
            r.tag = ppa_pkg::TAG_NULL;
        else
        begin
            op1 = q_mul(clamp(longint'(p.p1) - offs_d), gain_a);
            op2 = q_mul(clamp(longint'(p.p2) - offs_e), gain_b);
            case (cur_mode)
                ppa_pkg::MODE_ADD:      v = clamp(op1 + op2);
                ppa_pkg::MODE_SUBTRACT: v = clamp(op1 - op2);
                ppa_pkg::MODE_MULTIPLY: v = q_mul(op1, op2);
                default:
                    if (op2 == 0) r.tag = ppa_pkg::TAG_NULL;
                    else v = clamp((op1 * (longint'(1) <<< FB)) / op2);
            endcase
            if (r.tag == ppa_pkg::TAG_VALID) v = clamp(v + bias_c);
        end
        r.pix = (r.tag == ppa_pkg::TAG_VALID) ? PW'(v) : '0;
        return r;
    endfunction

    // input side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_pixels.push_back(compute_pixel(pending_pairs.pop_front()));
            end
            if (in_valid && !in_ready)
                ;
            else if (in_gap > 0)
            begin
                in_gap <= in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_pairs.size() > 0)
            begin
                if (!steady && $urandom_range(0, 7) == 0)
                begin
                    in_gap <= $urandom_range(1, 6) - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    first_pixel <= pending_pairs[0].p1;
                    first_special <= pending_pairs[0].t1;
                    second_pixel <= pending_pairs[0].p2;
                    second_special <= pending_pairs[0].t2;
                end
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output side
    always @(posedge clk)
    begin
        pixel_t want;
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected transaction pixel %h tag %0d", $time,
                             result_pixel, result_special);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    checked <= checked + 1;
                    if (want.pix !== result_pixel)
                    begin
                        errors = errors + 1;
                        $display("%0t: result_pixel expected %h actual %h", $time,
                                 want.pix, result_pixel);
                    end
                    if (want.tag !== result_special)
                    begin
                        errors = errors + 1;
                        $display("%0t: result_special expected %0d actual %0d", $time,
                                 want.tag, result_special);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_gap <= out_gap - 1;
                out_ready <= 1'b0;
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                out_gap <= $urandom_range(1, 6) - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout with %0d transactions outstanding",
                     pending_pairs.size() + expected_pixels.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [PW-1:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            ppa_pkg::REG_OP_MODE: cur_mode = val[2:0];
            ppa_pkg::REG_COEF_A:  gain_a = longint'(signed'(val));
            ppa_pkg::REG_COEF_B:  gain_b = longint'(signed'(val));
            ppa_pkg::REG_COEF_C:  bias_c = longint'(signed'(val));
            ppa_pkg::REG_COEF_D:  offs_d = longint'(signed'(val));
            ppa_pkg::REG_COEF_E:  offs_e = longint'(signed'(val));
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        while (pending_pairs.size() > 0 || expected_pixels.size() > 0 || in_valid)
            @(posedge clk);
    endtask

    function automatic logic [PW-1:0] pick_coef();
        case ($urandom_range(0, 9))
            0: return PW'(PIX_LO);
            1: return PW'(PIX_HI);
            2: return '0;
            3: return PW'($urandom);
            default: return PW'($urandom_range(0, 1 << (FB + 2)) - (1 << (FB + 1)));
        endcase
    endfunction

    function automatic logic signed [PW-1:0] pick_pixel();
        case ($urandom_range(0, 9))
            0: return PW'(PIX_LO);
            1: return PW'(PIX_HI);
            2, 3: return PW'($urandom);
            default: return PW'($urandom_range(0, 1 << (FB + 8)) - (1 << (FB + 7)));
        endcase
    endfunction

    function automatic ppa_pkg::tag_t pick_tag();
        if ($urandom_range(0, 4) != 0) return ppa_pkg::TAG_VALID;
        return ppa_pkg::tag_t'($urandom_range(1, 7));
    endfunction

    task automatic add_pair(logic signed [PW-1:0] p1, ppa_pkg::tag_t t1,
                            logic signed [PW-1:0] p2, ppa_pkg::tag_t t2);
        pair_t p;
        p.p1 = p1;
        p.t1 = t1;
        p.p2 = p2;
        p.t2 = t2;
        pending_pairs.push_back(p);
    endtask

    initial
    begin
        ppa_pkg::mode_t m;
        logic signed [PW-1:0] p2;
        cur_mode = ppa_pkg::MODE_UNARY;
        gain_a = longint'(1) <<< FB;
        gain_b = longint'(1) <<< FB;
        bias_c = 0;
        offs_d = 0;
        offs_e = 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset settings, then each operator with unit gains
        for (int i = 0; i < 6; i++)
        begin
            if (i > 0)
                write_reg(ppa_pkg::REG_OP_MODE,
                          PW'((i == 5) ? MODE_UNUSED : ppa_pkg::mode_t'(i - 1)));
            add_pair(PW'(PIX_HI), ppa_pkg::TAG_VALID, PW'(PIX_HI), ppa_pkg::TAG_VALID);
            add_pair(PW'(PIX_LO), ppa_pkg::TAG_VALID, PW'(PIX_LO), ppa_pkg::TAG_VALID);
            add_pair(PW'(1 << FB), ppa_pkg::TAG_VALID, '0, ppa_pkg::TAG_VALID);
            drain();
        end
        write_reg(ppa_pkg::REG_OP_MODE, PW'(ppa_pkg::MODE_DIVIDE));
        for (int t = 1; t < 8; t++)
            add_pair(PW'(3 << FB), ppa_pkg::tag_t'(t), PW'(1 << FB), ppa_pkg::TAG_VALID);
        add_pair(PW'(3 << FB), ppa_pkg::TAG_VALID, PW'(7), ppa_pkg::TAG_NULL);
        add_pair(PW'(3 << FB), ppa_pkg::TAG_VALID, PW'(5 << FB),
                 ppa_pkg::tag_t'(ppa_pkg::TAG_TOP + 2));
        add_pair(PW'(-(3 << FB)), ppa_pkg::TAG_VALID, PW'(-(2 << FB)), ppa_pkg::TAG_VALID);
        drain();

        // random phases, each with a fresh register set
        for (int ph = 0; ph < 22; ph++)
        begin
            steady = (ph >= 19);
            if ($urandom_range(0, 7) == 0) m = ppa_pkg::mode_t'($urandom_range(5, 7));
            else m = ppa_pkg::mode_t'($urandom_range(0, 4));
            write_reg(ppa_pkg::REG_OP_MODE, PW'(m));
            write_reg(ppa_pkg::REG_COEF_A, pick_coef());
            write_reg(ppa_pkg::REG_COEF_B, pick_coef());
            write_reg(ppa_pkg::REG_COEF_C, pick_coef());
            write_reg(ppa_pkg::REG_COEF_D, pick_coef());
            write_reg(ppa_pkg::REG_COEF_E, pick_coef());
            for (int k = 0; k < 50; k++)
            begin
                // second pixel equal to its offset gives a zero divisor
                p2 = ($urandom_range(0, 9) == 0) ? PW'(offs_e) : pick_pixel();
                add_pair(pick_pixel(), pick_tag(), p2, pick_tag());
            end
            drain();
        end
        repeat (LATENCY + 10) @(posedge clk);
        $display("checked %0d results over 22 random register sets and all operators",
                 checked);
        if (errors == 0 && expected_pixels.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// File: sim.f
sv/ppa_pkg.sv
sv/ppa_divider.sv
sv/pixel_pair_algebra_core.sv
tb/pixel_pair_algebra_core_test.sv
